FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SMF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg
// Types and constants shared by the substring match finder.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int CfgIdxW = 2;
  localparam int PatBytes = 8;
  localparam int PatW = 8 * PatBytes;
  localparam int LenW = 4;
  localparam int FieldW = 16;

  localparam logic [CfgIdxW-1:0] CFG_PATTERN_BYTES = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PATTERN_LENGTH = 2'd1;

  typedef struct packed {
    logic shift;  // text transaction accepted
    logic clear;  // current text byte ends the text
  } smf_ctrl_t;

  typedef struct packed {
    logic              found;
    logic [FieldW-1:0] first_position;
    logic [FieldW-1:0] match_count;
    logic              overflow;
  } smf_result_t;

endpackage

FILE: src/smf_intf.sv
// ----------------------------------------------------------------------------
// smf channel interfaces
// Valid/ready channels for configuration, text bytes and results.
// ----------------------------------------------------------------------------
interface smf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [smf_pkg::CfgIdxW-1:0]   index;
  logic [smf_pkg::PatW-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface smf_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;
  modport source (output valid, text_byte, last_byte, input ready);
  modport sink (input valid, text_byte, last_byte, output ready);
endinterface

interface smf_result_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [smf_pkg::FieldW-1:0]   first_position;
  logic [smf_pkg::FieldW-1:0]   match_count;
  logic                         overflow;
  modport source (output valid, found, first_position, match_count, overflow,
                  input ready);
  modport sink (input valid, found, first_position, match_count, overflow,
                output ready);
endinterface

FILE: src/smf_cell.sv
// ----------------------------------------------------------------------------
// smf_cell
// One window slot: holds a text byte and a fill bit, passes them on to the
// next slot on every transaction and compares the incoming byte with the
// pattern byte that lines up with this slot.
// ----------------------------------------------------------------------------
module smf_cell #(
  parameter int J = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  smf_pkg::smf_ctrl_t       ctrl_i,
  input  logic [7:0]               byte_i,
  input  logic                     vld_i,
  input  logic [smf_pkg::PatW-1:0] pattern_i,
  input  logic [smf_pkg::LenW-1:0] len_i,
  output logic [7:0]               byte_o,
  output logic                     vld_o,
  output logic                     hit_o
);

  logic [7:0] byte_q;
  logic       vld_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      vld_q <= vld_i && !ctrl_i.clear;
    end
  end

  assign byte_o = byte_q;
  assign vld_o  = vld_q;

  if (J < smf_pkg::PatBytes) begin : g_cmp
    logic [2:0] pidx;
    logic [7:0] pat;
    logic       used;

    // slot J holds pattern char len-1-J once the new byte is in
    assign used  = len_i > smf_pkg::LenW'(J);
    assign pidx  = 3'(len_i - smf_pkg::LenW'(J) - smf_pkg::LenW'(1));
    assign pat   = pattern_i[{pidx, 3'b000} +: 8];
    assign hit_o = !used || (vld_i && (byte_i == pat));
  end else begin : g_idle
    // beyond the longest pattern: slot only extends the window
    assign hit_o = 1'b1;
  end

endmodule

FILE: src/smf_tally.sv
// ----------------------------------------------------------------------------
// smf_tally
// Stream bookkeeping: byte position, first match start, saturating match
// count and overflow flag; forms the summary for the final byte.
// ----------------------------------------------------------------------------
module smf_tally #(
  parameter int POSITION_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  smf_pkg::smf_ctrl_t         ctrl_i,
  input  logic                       hit_i,
  input  logic [smf_pkg::LenW-1:0]   len_i,
  output smf_pkg::smf_result_t       summary_o
);

  localparam int PosW = POSITION_BITS + 1;

  logic [PosW-1:0]            pos_q, pos_d;
  logic [POSITION_BITS-1:0]   first_q, first_d;
  logic                       seen_q, seen_d;
  logic [smf_pkg::FieldW-1:0] cnt_q, cnt_d;
  logic                       too_long_q, too_long_d;
  logic                       in_range;
  logic [31:0]                fp_wide;

  always_comb begin
    in_range   = !pos_q[POSITION_BITS];
    too_long_d = too_long_q || !in_range;
    cnt_d      = (hit_i && (cnt_q != '1)) ? cnt_q + 1'b1 : cnt_q;
    seen_d     = seen_q || hit_i;
    first_d    = first_q;
    if (hit_i && !seen_q) begin
      if (in_range) begin
        first_d = POSITION_BITS'(pos_q - PosW'(len_i - smf_pkg::LenW'(1)));
      end else begin
        first_d = '1;
      end
    end
    pos_d = in_range ? pos_q + 1'b1 : pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      first_q    <= '0;
      seen_q     <= 1'b0;
      cnt_q      <= '0;
      too_long_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      if (ctrl_i.clear) begin
        pos_q      <= '0;
        first_q    <= '0;
        seen_q     <= 1'b0;
        cnt_q      <= '0;
        too_long_q <= 1'b0;
      end else begin
        pos_q      <= pos_d;
        first_q    <= first_d;
        seen_q     <= seen_d;
        cnt_q      <= cnt_d;
        too_long_q <= too_long_d;
      end
    end
  end

  // start positions above the 16-bit field clip to all ones
  assign fp_wide = seen_d ? 32'(first_d) : 32'd0;

  always_comb begin
    summary_o.found          = seen_d;
    summary_o.first_position = (|fp_wide[31:16]) ? '1 : fp_wide[15:0];
    summary_o.match_count    = cnt_d;
    summary_o.overflow       = too_long_d;
  end

endmodule

FILE: src/substring_match_finder_unit.sv
// Result: one summary per text, registered and valid in the cycle after the transaction that carries last_byte.
// Throughput: one text byte per cycle; the window is a chain of byte cells
// compared in parallel, so no byte waits on another.
// Input stalls only while a finished result waits in the output register.
// Reset: async, active low; pattern cleared, pattern length 1, stream empty.
// ----------------------------------------------------------------------------
// substring_match_finder_unit
// Sliding-window substring search over a byte stream with per-text summary.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module substring_match_finder_unit #(
  parameter int MAX_PATTERN   = 8,
  parameter int POSITION_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  smf_cfg_if.sink       cfg_i,
  smf_text_if.sink      text_i,
  smf_result_if.source  result_o
);

  logic [smf_pkg::PatW-1:0] pattern_q;
  logic [smf_pkg::LenW-1:0] plen_q;
  logic [smf_pkg::LenW-1:0] len;
  smf_pkg::smf_ctrl_t       ctrl;
  smf_pkg::smf_result_t     summary;
  smf_pkg::smf_result_t     res_q;
  logic                     res_vld_q;
  logic                     hit;

  logic [7:0]             cell_byte [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_vld;
  logic [MAX_PATTERN-1:0] cell_hit;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      plen_q    <= smf_pkg::LenW'(1);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        smf_pkg::CFG_PATTERN_BYTES:  pattern_q <= cfg_i.data;
        smf_pkg::CFG_PATTERN_LENGTH: plen_q    <= cfg_i.data[smf_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  // effective pattern length, 1..min(8, MAX_PATTERN)
  always_comb begin
    len = plen_q;
    if (len == '0) begin
      len = smf_pkg::LenW'(1);
    end
    if (len > smf_pkg::LenW'(smf_pkg::PatBytes)) begin
      len = smf_pkg::LenW'(smf_pkg::PatBytes);
    end
    if (int'(len) > MAX_PATTERN) begin
      len = smf_pkg::LenW'(MAX_PATTERN);
    end
  end

  assign text_i.ready = !res_vld_q || result_o.ready;
  assign ctrl.shift   = text_i.valid && text_i.ready;
  assign ctrl.clear   = text_i.last_byte;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [7:0] in_byte;
    logic       in_vld;
    if (j == 0) begin : g_head
      assign in_byte = text_i.text_byte;
      assign in_vld  = 1'b1;
    end else begin : g_link
      assign in_byte = cell_byte[j-1];
      assign in_vld  = cell_vld[j-1];
    end
    smf_cell #(.J(j)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .byte_i    (in_byte),
      .vld_i     (in_vld),
      .pattern_i (pattern_q),
      .len_i     (len),
      .byte_o    (cell_byte[j]),
      .vld_o     (cell_vld[j]),
      .hit_o     (cell_hit[j])
    );
  end

  assign hit = ctrl.shift && (&cell_hit);

  smf_tally #(.POSITION_BITS(POSITION_BITS)) u_tally (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .hit_i     (hit),
    .len_i     (len),
    .summary_o (summary)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (ctrl.shift && ctrl.clear) begin
      res_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.shift && ctrl.clear) begin
      res_q <= summary;
    end
  end

  assign result_o.valid          = res_vld_q;
  assign result_o.found          = res_q.found;
  assign result_o.first_position = res_q.first_position;
  assign result_o.match_count    = res_q.match_count;
  assign result_o.overflow       = res_q.overflow;

  `SMF_ASSERT_NEXT(a_result_after_last, clk_i, rst_ni, ctrl.shift && ctrl.clear, res_vld_q)
  `SMF_ASSERT_NOW(a_unfound_pos_zero, clk_i, rst_ni, res_vld_q && !res_q.found,
                  res_q.first_position == '0)
  `SMF_ASSERT_NOW(a_found_has_count, clk_i, rst_ni, res_vld_q,
                  res_q.found == (res_q.match_count != '0))

endmodule

FILE: sim/substring_match_finder_unit_tb.sv
// ----------------------------------------------------------------------------
// substring_match_finder_unit_tb
// Streams texts through the substring match finder and checks each per-text
// summary against its directed table entry or a cycle-free predictor of the
// window compare. A table of directed texts covers reset values, length
// clamping, overlap and short texts; random texts with random idling follow.
// ----------------------------------------------------------------------------
module substring_match_finder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TotalBytes = 1850;
  localparam int Settle = 3;
  localparam int QuietLimit = 1000;
  localparam logic [16:0] PosLimit = 17'h10000;
  // unmapped index, must be ignored
  localparam logic [smf_pkg::CfgIdxW-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [smf_pkg::PatW-1:0] pat;
    logic [smf_pkg::LenW-1:0] plen;
    logic [7:0]               fill;
    int                       fill_n;
    logic [smf_pkg::PatW-1:0] tail;
    int                       tail_n;
    logic                     fixed;
    smf_pkg::smf_result_t     sum;
  } text_row_t;

  typedef struct packed {
    logic                 fixed;
    smf_pkg::smf_result_t sum;
  } known_t;

  localparam logic [smf_pkg::PatW-1:0] Ones = {smf_pkg::PatW{1'b1}};

  localparam text_row_t Directed [11] = '{
    // reset config: pattern 0x00, length 1
    '{64'h0, 4'd1, 8'h00, 1, 64'h0, 0, 1'b1, '{1'b1, 16'd0, 16'd1, 1'b0}},
    '{64'h0, 4'd1, 8'hFF, 2, 64'h0, 0, 1'b1, '{1'b0, 16'd0, 16'd0, 1'b0}},
    '{Ones, 4'd8, 8'hFF, 8, 64'h0, 0, 1'b1, '{1'b1, 16'd0, 16'd1, 1'b0}},
    // text shorter than pattern
    '{Ones, 4'd8, 8'hFF, 7, 64'h0, 0, 1'b1, '{1'b0, 16'd0, 16'd0, 1'b0}},
    '{Ones, 4'd8, 8'hFF, 12, 64'h0, 0, 1'b1, '{1'b1, 16'd0, 16'd5, 1'b0}},
    // length zero acts as one
    '{Ones, 4'd0, 8'hFF, 3, 64'h0, 0, 1'b1, '{1'b1, 16'd0, 16'd3, 1'b0}},
    // length above 8 clamps to 8
    '{Ones, 4'd15, 8'hFF, 9, 64'h0, 0, 1'b1, '{1'b1, 16'd0, 16'd2, 1'b0}},
    '{64'h616261, 4'd3, 8'h00, 0, 64'h6162616261, 5, 1'b0, '0},
    '{64'h616261, 4'd3, 8'h78, 5, 64'h616261, 3, 1'b0, '0},
    '{64'h8040201008040201, 4'd8, 8'hFE, 3, 64'h8040201008040201, 8, 1'b1,
      '{1'b1, 16'd3, 16'd1, 1'b0}},
    // pattern is the whole text
    '{64'h4241, 4'd2, 8'h41, 0, 64'h4241, 2, 1'b1, '{1'b1, 16'd0, 16'd1, 1'b0}}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  smf_cfg_if    cfg_bus ();
  smf_text_if   text_bus ();
  smf_result_if sum_bus ();

  substring_match_finder_unit i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .text_i   (text_bus),
    .result_o (sum_bus)
  );

  always begin
    #4ns clk_i = 1'b1;
    #4ns clk_i = 1'b0;
  end

  // predictor state
  logic [smf_pkg::PatW-1:0] pat_q = '0;
  logic [smf_pkg::LenW-1:0] len_q = 4'd1;
  logic [7:0]               win [smf_pkg::PatBytes];
  int unsigned              held = 0;
  logic [16:0]              pos = '0;
  logic [15:0]              first = '0;
  logic                     seen = 1'b0;
  logic [15:0]              occ = '0;
  logic                     too_long = 1'b0;

  smf_pkg::smf_result_t summary_q [$];
  known_t               known_q [$];

  // stimulus-side copy of the programmed pattern
  logic [smf_pkg::PatW-1:0] cur_pat = '0;
  logic [smf_pkg::LenW-1:0] cur_len = 4'd1;

  bit steady = 1'b0;
  int mismatches = 0;
  int checked = 0;
  int texts = 0;
  int bytes_sent = 0;
  int quiet = 0;

  initial foreach (win[i]) win[i] = 8'h00;

  function automatic int unsigned eff_len(input logic [smf_pkg::LenW-1:0] n);
    if (n == 0) return 1;
    if (n > smf_pkg::PatBytes) return smf_pkg::PatBytes;
    return n;
  endfunction

  // shift one text byte in; returns 1 and the summary on the final byte
  function automatic bit scan_byte(input logic [7:0] b, input logic last,
                                   output smf_pkg::smf_result_t sum);
    int unsigned n;
    logic hit;
    logic in_range;
    n = eff_len(len_q);
    for (int i = smf_pkg::PatBytes - 1; i > 0; i--) win[i] = win[i-1];
    win[0] = b;
    if (held < smf_pkg::PatBytes) held++;
    in_range = pos < PosLimit;
    if (!in_range) too_long = 1'b1;
    hit = held >= n;
    // oldest byte of the window slice lines up with pattern byte 0
    for (int k = 0; k < n; k++)
      if (win[n-1-k] != pat_q[8*k +: 8]) hit = 1'b0;
    if (hit) begin
      if (occ != 16'hFFFF) occ++;
      if (!seen) begin
        seen = 1'b1;
        first = in_range ? 16'(pos - 17'(n - 1)) : 16'hFFFF;
      end
    end
    if (in_range) pos++;
    sum = '{seen, seen ? first : 16'd0, occ, too_long};
    if (last) begin
      foreach (win[i]) win[i] = 8'h00;
      held = 0;
      pos = '0;
      first = '0;
      seen = 1'b0;
      occ = '0;
      too_long = 1'b0;
    end
    return last;
  endfunction

  always @(posedge clk_i) sum_bus.ready <= steady || ($urandom_range(99) >= 27);

  // monitor: check summaries, track register writes, predict per byte
  always @(posedge clk_i) begin
    smf_pkg::smf_result_t got;
    smf_pkg::smf_result_t want;
    smf_pkg::smf_result_t pred;
    known_t               note;
    if (rst_ni) begin
      if (sum_bus.valid && sum_bus.ready) begin
        got = '{sum_bus.found, sum_bus.first_position, sum_bus.match_count,
                sum_bus.overflow};
        if (summary_q.size() == 0) begin
          $error("summary with none expected: %p", got);
          mismatches++;
        end else begin
          want = summary_q.pop_front();
          checked++;
          if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            mismatches++;
          end
          if (got.first_position !== want.first_position) begin
            $error("first_position: expected %0d, got %0d",
                   want.first_position, got.first_position);
            mismatches++;
          end
          if (got.match_count !== want.match_count) begin
            $error("match_count: expected %0d, got %0d",
                   want.match_count, got.match_count);
            mismatches++;
          end
          if (got.overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
            mismatches++;
          end
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          smf_pkg::CFG_PATTERN_BYTES:  pat_q = cfg_bus.data;
          smf_pkg::CFG_PATTERN_LENGTH: len_q = cfg_bus.data[smf_pkg::LenW-1:0];
          default: ;
        endcase
      end
      if (text_bus.valid && text_bus.ready) begin
        if (scan_byte(text_bus.text_byte, text_bus.last_byte, pred)) begin
          note = (known_q.size() != 0) ? known_q.pop_front() : '0;
          summary_q.push_back(note.fixed ? note.sum : pred);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (text_bus.valid && text_bus.ready) ||
        (sum_bus.valid && sum_bus.ready) || (cfg_bus.valid && cfg_bus.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == QuietLimit) begin
      $display("timeout: no transaction for %0d cycles", QuietLimit);
      $display("substring_match_finder_unit_tb: done, errors");
      $finish;
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(99) < 27) begin
      text_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    text_bus.valid     <= 1'b1;
    text_bus.text_byte <= b;
    text_bus.last_byte <= last;
    do @(posedge clk_i); while (!text_bus.ready);
    bytes_sent++;
  endtask

  task automatic put_reg(input logic [smf_pkg::CfgIdxW-1:0] idx,
                         input logic [smf_pkg::PatW-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
  endtask

  // wait for all summaries, then write the pattern registers
  task automatic program_pattern(input logic [smf_pkg::PatW-1:0] pat,
                                 input logic [smf_pkg::PatW-1:0] len_word,
                                 input bit spare);
    text_bus.valid <= 1'b0;
    // let the monitor queue the summary of the final byte first
    @(posedge clk_i);
    while (summary_q.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
    put_reg(smf_pkg::CFG_PATTERN_BYTES, pat);
    put_reg(smf_pkg::CFG_PATTERN_LENGTH, len_word);
    if (spare) put_reg(CFG_SPARE, {$urandom, $urandom});
    cfg_bus.valid <= 1'b0;
    cur_pat = pat;
    cur_len = len_word[smf_pkg::LenW-1:0];
  endtask

  initial begin
    text_row_t                row;
    logic [7:0]               chars [$];
    logic [smf_pkg::PatW-1:0] pat;
    logic [smf_pkg::LenW-1:0] plen;
    int                       total;
    int                       n_eff;
    int                       kind;
    int                       want_n;
    int                       span;

    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = smf_pkg::CFG_PATTERN_BYTES;
    cfg_bus.data       = '0;
    text_bus.valid     = 1'b0;
    text_bus.text_byte = 8'h00;
    text_bus.last_byte = 1'b0;
    sum_bus.ready      = 1'b0;
    rst_ni             = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (Directed[r]) begin
      row = Directed[r];
      if (row.pat != cur_pat || row.plen != cur_len)
        program_pattern(row.pat, smf_pkg::PatW'(row.plen), 1'b0);
      known_q.push_back('{row.fixed, row.sum});
      total = row.fill_n + row.tail_n;
      for (int i = 0; i < total; i++)
        put_byte((i < row.fill_n) ? row.fill : row.tail[8*(i-row.fill_n) +: 8],
                 i == total - 1);
      texts++;
    end

    while (bytes_sent < TotalBytes) begin
      if (texts == $size(Directed) || $urandom_range(2) == 0) begin
        case ($urandom_range(9))
          0:       pat = '0;
          1:       pat = Ones;
          default: pat = {$urandom, $urandom};
        endcase
        plen = ($urandom_range(9) == 0) ? smf_pkg::LenW'($urandom_range(15))
                                        : smf_pkg::LenW'($urandom_range(1, 8));
        // upper data bits are don't-care for the length register
        program_pattern(pat, {$urandom, 15'($urandom_range(0, 15'h7FFF)), 13'd0, plen},
                        $urandom_range(7) == 0);
      end
      steady = (texts >= $size(Directed) + 30) && (texts < $size(Directed) + 50);
      n_eff = eff_len(cur_len);
      kind = $urandom_range(9);
      want_n = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      chars.delete();
      while (chars.size() < want_n) begin
        if (kind >= 6 && $urandom_range(2) == 0) begin
          // full copy mostly, sometimes a broken prefix
          span = ($urandom_range(3) == 0) ? $urandom_range(1, n_eff) : n_eff;
          for (int k = 0; k < span; k++) chars.push_back(cur_pat[8*k +: 8]);
        end else if (kind >= 2 && $urandom_range(3) != 0)
          chars.push_back(cur_pat[8*$urandom_range(n_eff - 1) +: 8]);
        else
          chars.push_back(8'($urandom));
      end
      known_q.push_back('0);
      foreach (chars[i]) put_byte(chars[i], i == chars.size() - 1);
      texts++;
    end

    steady = 1'b0;
    text_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (summary_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d texts, %0d bytes sent, %0d summaries compared", texts, bytes_sent,
             checked);
    $display("lengths 0..15 with clamping, overlap, short texts, random idling");
    if (mismatches == 0)
      $display("substring_match_finder_unit_tb: done, clean");
    else
      $display("substring_match_finder_unit_tb: done, errors");
    $finish;
  end

endmodule
